// ----- rtl/rd16_pkg.sv -----
// shared types for the pipelined restoring divider
package rd16_pkg;

    // per-word sign and exception flags that ride along the divider pipe
    typedef struct packed {
        logic neg_q;   // quotient must be negated at the end
        logic neg_r;   // remainder must be negated at the end
        logic zdiv;    // denominator was zero
    } t_div_flags;

endpackage

// ----- rtl/restoring_divider_16_unit.sv -----
// top level: pipelined signed/unsigned restoring divider with stream ports
// stages: one operand prep stage, one stage per quotient bit, one output stage with
//   sign fix-up
// throughput: one division per cycle unless the output stalls; every stage has its
//   own valid and ready: bubbles close up, and while a result waits the pipe fills up
// reset: synchronous active-low, clears only the stage valid bits
module restoring_divider_16_unit #(
    parameter int WORD_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // numerator [WORD_BITS-1:0], denominator next, zero fill to whole bytes
    input  logic [((2 * WORD_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
    // signed_mode
    input  logic [0:0]                            s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // quotient [WORD_BITS-1:0], remainder next, zero fill to whole bytes
    output logic [((2 * WORD_BITS + 7) / 8) * 8-1:0] m_axis_tdata,
    // zero_divisor
    output logic [0:0]                            m_axis_tuser
);

    localparam int W             = WORD_BITS;
    localparam int OUT_DATA_BITS = ((2 * WORD_BITS + 7) / 8) * 8;

    // ------------------------------------------------------------------
    // operand prep: magnitudes, sign flags, zero divisor detect
    // ------------------------------------------------------------------
    logic [W-1:0] in_num;
    logic [W-1:0] in_den;
    logic         in_sgn;
    logic         in_zd;
    logic         in_ns;
    logic         in_ds;
    logic [W-1:0] n_pre_num;
    logic [W-1:0] n_pre_den;
    rd16_pkg::t_div_flags n_pre_flags;

    assign in_num = s_axis_tdata[W-1:0];
    assign in_den = s_axis_tdata[2*W-1:W];
    assign in_sgn = s_axis_tuser[0];
    assign in_zd  = (in_den == '0);

    // on a zero divisor run an unsigned pass: dividing by zero just shifts
    // the numerator through the remainder, so the raw word falls out
    assign in_ns = in_sgn && in_num[W-1] && !in_zd;
    assign in_ds = in_sgn && in_den[W-1] && !in_zd;

    assign n_pre_num         = in_ns ? (W'(0) - in_num) : in_num;
    assign n_pre_den         = in_ds ? (W'(0) - in_den) : in_den;
    assign n_pre_flags.neg_q = in_ns ^ in_ds;
    assign n_pre_flags.neg_r = in_ns;
    assign n_pre_flags.zdiv  = in_zd;

    // stage arrays: index 0 is the prep register, k+1 is the output of cell k
    logic                 st_valid [0:W];
    logic                 st_ready [0:W];
    logic [W-1:0]         st_rq    [0:W];
    logic [W-1:0]         st_rem   [0:W];
    logic [W-1:0]         st_dm    [0:W];
    rd16_pkg::t_div_flags st_flags [0:W];

    logic                 r_pre_valid;
    logic [W-1:0]         r_pre_num;
    logic [W-1:0]         r_pre_den;
    rd16_pkg::t_div_flags r_pre_flags;

    assign s_axis_tready = !r_pre_valid || st_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_pre_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_pre_num   <= n_pre_num;
            r_pre_den   <= n_pre_den;
            r_pre_flags <= n_pre_flags;
        end
    end

    // partial remainder starts at zero; the numerator shifts out of rq as
    // quotient bits shift in
    assign st_valid[0] = r_pre_valid;
    assign st_rq[0]    = r_pre_num;
    assign st_rem[0]   = '0;
    assign st_dm[0]    = r_pre_den;
    assign st_flags[0] = r_pre_flags;

    // ------------------------------------------------------------------
    // chain of restoring cells, one quotient bit each
    // ------------------------------------------------------------------
    for (genvar k = 0; k < W; k++) begin : g_cell
        rd16_cell #(
            .W (W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (st_valid[k]),
            .o_ready (st_ready[k]),
            .i_rq    (st_rq[k]),
            .i_rem   (st_rem[k]),
            .i_dm    (st_dm[k]),
            .i_flags (st_flags[k]),
            .o_valid (st_valid[k+1]),
            .i_ready (st_ready[k+1]),
            .o_rq    (st_rq[k+1]),
            .o_rem   (st_rem[k+1]),
            .o_dm    (st_dm[k+1]),
            .o_flags (st_flags[k+1])
        );
    end

    // ------------------------------------------------------------------
    // output stage: sign fix-up and zero divisor override
    // ------------------------------------------------------------------
    rd16_pkg::t_div_flags last_flags;
    logic [W-1:0]         n_out_quo;
    logic [W-1:0]         n_out_rem;
    logic                 r_out_valid;
    logic [W-1:0]         r_out_quo;
    logic [W-1:0]         r_out_rem;
    logic                 r_out_zd;

    assign last_flags = st_flags[W];

    always_comb begin
        if (last_flags.zdiv) begin
            n_out_quo = '0;
        end else if (last_flags.neg_q) begin
            n_out_quo = W'(0) - st_rq[W];
        end else begin
            n_out_quo = st_rq[W];
        end
        n_out_rem = last_flags.neg_r ? (W'(0) - st_rem[W]) : st_rem[W];
    end

    assign st_ready[W] = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (st_ready[W]) begin
            r_out_valid <= st_valid[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (st_valid[W] && st_ready[W]) begin
            r_out_quo <= n_out_quo;
            r_out_rem <= n_out_rem;
            r_out_zd  <= last_flags.zdiv;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = OUT_DATA_BITS'({r_out_rem, r_out_quo});
    assign m_axis_tuser[0] = r_out_zd;

`ifndef SYNTHESIS
    // reset empties the output stage
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("output valid set after reset");

    // after the last step the remainder magnitude is below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (st_valid[W] && !last_flags.zdiv) |-> (st_rem[W] < st_dm[W]))
        else $error("remainder not below divisor after last step");

    // a zero divisor result always carries a zero quotient
    a_zdiv_quo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_zd) |-> (r_out_quo == '0))
        else $error("nonzero quotient on zero divisor");

    // a word entering the chain lands in the first cell next cycle
    a_chain_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (st_valid[0] && st_ready[0]) |=> st_valid[1])
        else $error("word lost entering the cell chain");
`endif

endmodule

// ----- rtl/rd16_cell.sv -----
// one restoring step of the divider, registered, with its own handshake
module rd16_cell #(
    parameter int W = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [W-1:0]         i_rq,
    input  logic [W-1:0]         i_rem,
    input  logic [W-1:0]         i_dm,
    input  rd16_pkg::t_div_flags i_flags,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [W-1:0]         o_rq,
    output logic [W-1:0]         o_rem,
    output logic [W-1:0]         o_dm,
    output rd16_pkg::t_div_flags o_flags
);

    logic                 r_valid;
    logic [W-1:0]         r_rq;
    logic [W-1:0]         r_rem;
    logic [W-1:0]         r_dm;
    rd16_pkg::t_div_flags r_flags;

    logic [W:0]   cand;
    logic [W:0]   diff;
    logic         ge;
    logic [W-1:0] n_rq;
    logic [W-1:0] n_rem;
    logic         load;

    // shift the next numerator bit into the partial remainder, try subtract
    assign cand  = {i_rem, i_rq[W-1]};
    assign diff  = cand - {1'b0, i_dm};
    assign ge    = (cand >= {1'b0, i_dm});
    assign n_rem = ge ? diff[W-1:0] : cand[W-1:0];
    assign n_rq  = {i_rq[W-2:0], ge};

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rq    <= n_rq;
            r_rem   <= n_rem;
            r_dm    <= i_dm;
            r_flags <= i_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_rq    = r_rq;
    assign o_rem   = r_rem;
    assign o_dm    = r_dm;
    assign o_flags = r_flags;

endmodule

// ----- verif/restoring_divider_16_unit_tb.sv -----
// stream testbench for the pipelined 16-bit restoring divider with a divide predictor
`timescale 1ns / 100ps

module restoring_divider_16_unit_tb;

    localparam int DIV_BITS   = 16;
    localparam int WORD_DATA  = 2 * DIV_BITS;     // two fields, already whole bytes
    localparam int PIPE_DEPTH = DIV_BITS + 2;     // prep stage, one per bit, sign fix-up
    localparam int RAND_DIVS  = 950;

    // one expected division outcome
    typedef struct packed {
        logic [DIV_BITS-1:0] quotient;
        logic [DIV_BITS-1:0] remainder;
        logic                zero_divisor;
    } t_div_result;

    // holds the quotient/remainder words still owed by the pipe, in order of acceptance
    class division_ledger;
        t_div_result owed[$];
        int          mismatches;
        int          divisions;
        int          signed_divs;
        int          by_zero;
        int          checked;

        // sixteen restoring steps on magnitudes, signs fixed up afterwards
        function t_div_result divide_word(logic [DIV_BITS-1:0] num,
                                          logic [DIV_BITS-1:0] den, logic sgn);
            t_div_result         res;
            logic [DIV_BITS-1:0] num_mag;
            logic [DIV_BITS-1:0] den_mag;
            logic [DIV_BITS-1:0] quo;
            logic [DIV_BITS-1:0] part;
            logic                spill;
            logic                num_neg;
            logic                den_neg;
            int                  i;
            if (den == '0) begin
                res.quotient     = '0;
                res.remainder    = num;
                res.zero_divisor = 1'b1;
                return res;
            end
            num_neg = sgn & num[DIV_BITS-1];
            den_neg = sgn & den[DIV_BITS-1];
            num_mag = num_neg ? (~num + 1'b1) : num;
            den_mag = den_neg ? (~den + 1'b1) : den;
            quo     = '0;
            part    = '0;
            for (i = DIV_BITS - 1; i >= 0; i--) begin
                // bit shifted out of the partial remainder means it already exceeds the divisor
                spill = part[DIV_BITS-1];
                part  = {part[DIV_BITS-2:0], num_mag[i]};
                quo   = {quo[DIV_BITS-2:0], 1'b0};
                if (spill || part >= den_mag) begin
                    part   = part - den_mag;
                    quo[0] = 1'b1;
                end
            end
            res.remainder    = num_neg ? (~part + 1'b1) : part;
            res.quotient     = (num_neg != den_neg) ? (~quo + 1'b1) : quo;
            res.zero_divisor = 1'b0;
            return res;
        endfunction

        function void note_operands(logic [DIV_BITS-1:0] num, logic [DIV_BITS-1:0] den,
                                    logic sgn);
            owed.push_back(divide_word(num, den, sgn));
            divisions++;
            if (sgn) signed_divs++;
            if (den == '0) by_zero++;
        endfunction

        function void check_result(logic [DIV_BITS-1:0] quo, logic [DIV_BITS-1:0] rem,
                                   logic zdiv);
            t_div_result want;
            if (owed.size() == 0) begin
                $display("%0t: unexpected word q=%h r=%h z=%b", $time, quo, rem, zdiv);
                mismatches++;
                return;
            end
            want = owed.pop_front();
            checked++;
            if (quo !== want.quotient) begin
                $display("%0t: quotient expected %h got %h", $time, want.quotient, quo);
                mismatches++;
            end
            if (rem !== want.remainder) begin
                $display("%0t: remainder expected %h got %h", $time, want.remainder, rem);
                mismatches++;
            end
            if (zdiv !== want.zero_divisor) begin
                $display("%0t: zero_divisor expected %b got %b", $time, want.zero_divisor,
                         zdiv);
                mismatches++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [WORD_DATA-1:0] s_axis_tdata;    // numerator [15:0], denominator [31:16]
    logic [0:0]           s_axis_tuser;    // signed_mode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [WORD_DATA-1:0] m_axis_tdata;    // quotient [15:0], remainder [31:16]
    logic [0:0]           m_axis_tuser;    // zero_divisor

    division_ledger ledger;
    bit             steady;                // no idling on either side while set
    int             stall_left;

    restoring_divider_16_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // idle length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // operand pattern biased toward the corners of the division
    function automatic logic [DIV_BITS-1:0] pick_word();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return DIV_BITS'($urandom);
        if (roll < 65) return DIV_BITS'($urandom_range(0, 15));
        if (roll < 75) return ~DIV_BITS'($urandom_range(0, 15));   // small negatives
        case ($urandom_range(0, 6))
            0: return 16'h0000;
            1: return 16'h0001;
            2: return 16'h7fff;
            3: return 16'h8000;
            4: return 16'h8001;
            5: return 16'hfffe;
            default: return 16'hffff;
        endcase
    endfunction

    // offer one word, hold it until the divider takes it
    task automatic send_division(logic [DIV_BITS-1:0] num, logic [DIV_BITS-1:0] den,
                                 logic sgn);
        int gap;
        gap = steady ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {den, num};
        s_axis_tuser  <= sgn;
        do @(posedge i_clk); while (!s_axis_tready);
        ledger.note_operands(num, den, sgn);
    endtask

    // receive side back-pressure
    initial begin
        m_axis_tready = 1'b0;
        stall_left    = 0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!steady) stall_left = pick_gap();
            end
        end
    end

    // results are sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            ledger.check_result(m_axis_tdata[DIV_BITS-1:0],
                                m_axis_tdata[WORD_DATA-1:DIV_BITS], m_axis_tuser[0]);
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #4000000;
        $display("FAIL restoring_divider_16_unit");
        $finish;
    end

    initial begin
        logic [DIV_BITS-1:0] num;
        logic [DIV_BITS-1:0] den;
        int                  roll;
        int                  drain;
        ledger        = new();
        steady        = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // corners: zero divisor in both modes, most negative over minus one,
        // sign combinations for truncation toward zero, full-scale operands
        send_division(16'h0000, 16'h0000, 1'b0);
        send_division(16'h0000, 16'h0000, 1'b1);
        send_division(16'hffff, 16'h0000, 1'b0);
        send_division(16'h8000, 16'h0000, 1'b1);
        send_division(16'h1234, 16'h0000, 1'b1);
        send_division(16'h8000, 16'hffff, 1'b1);
        send_division(16'h8000, 16'hffff, 1'b0);
        send_division(16'hffff, 16'hffff, 1'b0);
        send_division(16'hffff, 16'h0001, 1'b0);
        send_division(16'hffff, 16'h0001, 1'b1);
        send_division(16'h7fff, 16'h0001, 1'b1);
        send_division(16'h7fff, 16'h8000, 1'b1);
        send_division(16'h8000, 16'h8000, 1'b1);
        send_division(16'h8000, 16'h0001, 1'b1);
        send_division(16'h8000, 16'h7fff, 1'b1);
        send_division(16'hff9c, 16'h0007, 1'b1);   // -100 / 7
        send_division(16'h0064, 16'hfff9, 1'b1);   // 100 / -7
        send_division(16'hff9c, 16'hfff9, 1'b1);   // -100 / -7
        send_division(16'h0000, 16'hffff, 1'b1);
        send_division(16'h7fff, 16'h7fff, 1'b0);
        send_division(16'h0001, 16'hffff, 1'b0);
        send_division(16'hffff, 16'h8000, 1'b0);
        send_division(16'h0005, 16'h0003, 1'b0);

        for (int n = 0; n < RAND_DIVS; n++) begin
            // back-to-back stretches with no idling on either side
            steady = (n >= 300 && n < 420) || (n >= 700 && n < 760);
            num  = pick_word();
            roll = $urandom_range(0, 99);
            if (roll < 6)
                den = '0;
            else if (roll < 14)
                den = num;
            else if (roll < 24)
                den = num >> $urandom_range(1, 12);
            else
                den = pick_word();
            send_division(num, den, 1'($urandom));
        end
        steady = 1'b0;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        // let the pipe drain, then watch a little longer for stray words
        drain = 0;
        while (ledger.owed.size() != 0 && drain < 100000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (PIPE_DEPTH * 3) @(posedge i_clk);

        $display("ran %0d divisions (%0d signed, %0d by zero), %0d results checked",
                 ledger.divisions, ledger.signed_divs, ledger.by_zero, ledger.checked);
        $display("%0d words left unanswered, %0d mismatches",
                 ledger.owed.size(), ledger.mismatches);
        if (ledger.mismatches == 0 && ledger.owed.size() == 0) begin
            $display("PASS restoring_divider_16_unit");
        end else begin
            $display("FAIL restoring_divider_16_unit");
        end
        $finish;
    end

endmodule
